// ===== src/double_ended_stack_allocator_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended stack allocator
// Shared property wrappers; clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_CORE_ASSERT_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define DESA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DESA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/desa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// desa_pkg
// Types and constants shared by the double-ended stack allocator modules.
// ---------------------------------------------------------------------------
package desa_pkg;

   localparam int unsigned FIELD_BITS = 32;
   localparam logic [FIELD_BITS-1:0] REGION_RESET = 32'h0001_0000;

   typedef enum logic [2:0] {
      CMD_ALLOC_TOP     = 3'd0,
      CMD_ALLOC_BOTTOM  = 3'd1,
      CMD_FREE_TOP      = 3'd2,
      CMD_FREE_BOTTOM   = 3'd3,
      CMD_TOP_MARKER    = 3'd4,
      CMD_BOTTOM_MARKER = 3'd5,
      CMD_CLEAR_TOP     = 3'd6,
      CMD_CLEAR_BOTTOM  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_ZERO_SIZE = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_REGION_SIZE  = 1'b0,
      CSR_BASE_ADDRESS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] region_size;
      logic [FIELD_BITS-1:0] base_address;
   } csr_regs_type;

   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] address;
   } result_type;

endpackage

// ===== src/desa_csr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// desa_csr
// Configuration registers: region size and base address.
// ---------------------------------------------------------------------------
module desa_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  desa_pkg::csr_index_type       csr_index,
   input  logic [desa_pkg::FIELD_BITS-1:0] csr_wdata,
   output desa_pkg::csr_regs_type        regs
);
   import desa_pkg::*;

   logic [FIELD_BITS-1:0] region_ff, region_in;
   logic [FIELD_BITS-1:0] base_ff, base_in;

   // writes must only arrive while the core is idle (the block does not enforce it); never back-pressured
   assign csr_ready = 1'b1;

   always_comb begin
      region_in = region_ff;
      base_in   = base_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REGION_SIZE:  region_in = csr_wdata;
            CSR_BASE_ADDRESS: base_in   = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= REGION_RESET;
         base_ff   <= '0;
      end else begin
         region_ff <= region_in;
         base_ff   <= base_in;
      end
   end

   assign regs.region_size  = region_ff;
   assign regs.base_address = base_ff;

endmodule

// ===== src/desa_exec.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// desa_exec
// Command datapath: computes status, address and next pointer values.
// ---------------------------------------------------------------------------
module desa_exec #(
   parameter int unsigned PTR_BITS = 32
) (
   input  desa_pkg::cmd_type               cmd,
   input  logic [desa_pkg::FIELD_BITS-1:0] size,
   input  logic [3:0]                      align_log2,
   input  logic [desa_pkg::FIELD_BITS-1:0] marker,
   input  desa_pkg::csr_regs_type          regs,
   input  logic [PTR_BITS-1:0]             top_cur,
   input  logic [PTR_BITS-1:0]             bottom_cur,
   output logic [PTR_BITS-1:0]             top_next,
   output logic [PTR_BITS-1:0]             bottom_next,
   output desa_pkg::result_type            result
);
   import desa_pkg::*;

   // room for an aligned-up bottom plus a size without wrapping
   localparam int unsigned EXT_BITS = ((PTR_BITS > 15) ? PTR_BITS : 15) + 2;

   logic [PTR_BITS-1:0] size_m;
   logic [PTR_BITS-1:0] marker_m;
   logic [PTR_BITS-1:0] region_m;
   logic [EXT_BITS-1:0] amask;
   logic [PTR_BITS-1:0] top_start;
   logic [EXT_BITS-1:0] bot_start;
   logic [EXT_BITS-1:0] bot_end;
   logic [PTR_BITS-1:0] top_room;
   logic                is_sized;

   assign size_m   = size[PTR_BITS-1:0];
   assign marker_m = marker[PTR_BITS-1:0];
   assign region_m = regs.region_size[PTR_BITS-1:0];
   assign amask    = ~({EXT_BITS{1'b1}} << align_log2);
   assign is_sized = (cmd == CMD_ALLOC_TOP) || (cmd == CMD_ALLOC_BOTTOM) ||
                     (cmd == CMD_FREE_TOP) || (cmd == CMD_FREE_BOTTOM);

   // top start rounds down, bottom start rounds up
   assign top_start = (top_cur - size_m) & ~amask[PTR_BITS-1:0];
   assign bot_start = (EXT_BITS'(bottom_cur) + amask) & ~amask;
   assign bot_end   = bot_start + EXT_BITS'(size_m);
   assign top_room  = region_m - top_cur;

   always_comb begin
      top_next       = top_cur;
      bottom_next    = bottom_cur;
      result.status  = STATUS_OK;
      result.address = '0;
      if (is_sized && (size_m == '0)) begin
         result.status = STATUS_ZERO_SIZE;
      end else begin
         unique case (cmd)
            CMD_ALLOC_TOP: begin
               if ((size_m > top_cur) || (top_start <= bottom_cur)) begin
                  result.status = STATUS_OVERFLOW;
               end else begin
                  top_next       = top_start;
                  result.address = regs.base_address + FIELD_BITS'(top_start);
               end
            end
            CMD_ALLOC_BOTTOM: begin
               if (bot_end >= EXT_BITS'(top_cur)) begin
                  result.status = STATUS_OVERFLOW;
               end else begin
                  bottom_next    = bot_end[PTR_BITS-1:0];
                  result.address = regs.base_address +
                                   FIELD_BITS'(bot_start[PTR_BITS-1:0]);
               end
            end
            CMD_FREE_TOP: begin
               // saturate at the region end, also when top already sits past it
               if ((top_cur >= region_m) || (size_m > top_room)) begin
                  top_next = region_m;
               end else begin
                  top_next = top_cur + size_m;
               end
            end
            CMD_FREE_BOTTOM: begin
               if (size_m > bottom_cur) begin
                  bottom_next = '0;
               end else begin
                  bottom_next = bottom_cur - size_m;
               end
            end
            CMD_TOP_MARKER: begin
               if ((marker_m > top_cur) && (marker_m < region_m)) begin
                  top_next = marker_m;
               end
            end
            CMD_BOTTOM_MARKER: begin
               if (marker_m < bottom_cur) begin
                  bottom_next = marker_m;
               end
            end
            CMD_CLEAR_TOP:    top_next    = region_m;
            CMD_CLEAR_BOTTOM: bottom_next = '0;
         endcase
      end
   end

endmodule

// ===== src/double_ended_stack_allocator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_ended_stack_allocator_core
// Two-ended bump allocator over one region, one command per cycle while the result side does not stall.
// ---------------------------------------------------------------------------
// A command transfer lands in an input register; once the result slot is free
// or being drained, its result is computed from that register and the two
// pointer registers, and the pointers and the result register are updated
// together, so a following command already sees the new pointers. Throughput
// is one command per cycle with no stall on either side; result valid comes
// from the result register, which is loaded as the command leaves the input
// register. Only a stalled result slot holds the input register.
// Configuration writes are taken at once and must only be issued while idle.
module double_ended_stack_allocator_core #(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  desa_pkg::cmd_type               req_cmd,
   input  logic [desa_pkg::FIELD_BITS-1:0] req_size,
   input  logic [3:0]                      req_align_log2,
   input  logic [desa_pkg::FIELD_BITS-1:0] req_marker,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output desa_pkg::status_type            rsp_status,
   output logic [desa_pkg::FIELD_BITS-1:0] rsp_address,
   output logic [desa_pkg::FIELD_BITS-1:0] rsp_top_now,
   output logic [desa_pkg::FIELD_BITS-1:0] rsp_bottom_now,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  desa_pkg::csr_index_type         csr_index,
   input  logic [desa_pkg::FIELD_BITS-1:0] csr_wdata
);
   import desa_pkg::*;

   localparam int unsigned PTR_BITS = (OFFSET_BITS < FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;

`include "double_ended_stack_allocator_core_assert.svh"

   csr_regs_type regs;
   result_type   exec_result;

   logic                  req_valid_ff, req_valid_in;
   cmd_type               cmd_ff, cmd_in;
   logic [FIELD_BITS-1:0] size_ff, size_in;
   logic [3:0]            align_ff, align_in;
   logic [FIELD_BITS-1:0] marker_ff, marker_in;

   logic [PTR_BITS-1:0]   top_ff, top_in;
   logic [PTR_BITS-1:0]   bottom_ff, bottom_in;
   logic [PTR_BITS-1:0]   top_next;
   logic [PTR_BITS-1:0]   bottom_next;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [FIELD_BITS-1:0] address_ff, address_in;

   logic                  req_xfer;
   logic                  advance;

   desa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   desa_exec #(
      .PTR_BITS (PTR_BITS)
   ) u_exec (
      .cmd         (cmd_ff),
      .size        (size_ff),
      .align_log2  (align_ff),
      .marker      (marker_ff),
      .regs        (regs),
      .top_cur     (top_ff),
      .bottom_cur  (bottom_ff),
      .top_next    (top_next),
      .bottom_next (bottom_next),
      .result      (exec_result)
   );

   // held command moves on when the result slot is free or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      cmd_in       = cmd_ff;
      size_in      = size_ff;
      align_in     = align_ff;
      marker_in    = marker_ff;
      if (req_xfer) begin
         req_valid_in = 1'b1;
         cmd_in       = req_cmd;
         size_in      = req_size;
         align_in     = req_align_log2;
         marker_in    = req_marker;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      address_in   = address_ff;
      if (advance) begin
         top_in       = top_next;
         bottom_in    = bottom_next;
         rsp_valid_in = 1'b1;
         status_in    = exec_result.status;
         address_in   = exec_result.address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         top_ff       <= REGION_RESET[PTR_BITS-1:0];
         bottom_ff    <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
         bottom_ff    <= bottom_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      size_ff    <= size_in;
      align_ff   <= align_in;
      marker_ff  <= marker_in;
      status_ff  <= status_in;
      address_ff <= address_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_address    = address_ff;
   assign rsp_top_now    = FIELD_BITS'(top_ff);
   assign rsp_bottom_now = FIELD_BITS'(bottom_ff);

   `DESA_ASSERT_NEXT(a_fail_keeps_ptrs,
      advance && (exec_result.status != STATUS_OK),
      $stable(top_ff) && $stable(bottom_ff),
      "failed command changed a pointer")

   `DESA_ASSERT_NEXT(a_alloc_no_cross,
      advance && (exec_result.status == STATUS_OK) &&
      ((cmd_ff == CMD_ALLOC_TOP) || (cmd_ff == CMD_ALLOC_BOTTOM)),
      bottom_ff < top_ff,
      "allocation left pointers crossed")

   `DESA_ASSERT_IMPL(a_addr_zero_on_fail,
      rsp_valid && (rsp_status != STATUS_OK),
      rsp_address == '0,
      "nonzero address on failed command")

   `DESA_ASSERT_IMPL(a_rsp_ptrs_live,
      rsp_valid,
      (rsp_top_now == FIELD_BITS'(top_ff)) && (rsp_bottom_now == FIELD_BITS'(bottom_ff)),
      "result pointers differ from pointer registers")

endmodule
